### design/cvrf_pkg.sv
// Package for the changed-value report filter.
// Holds the shared constants, the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package cvrf_pkg;

    localparam int unsigned SLOTS_DEFAULT = 8;
    localparam logic [31:0] REFRESH_RESET = 32'd60000;
    localparam logic [7:0]  STATUS_ID     = 8'd0;

    localparam int unsigned CFG_ADDR_W      = 3;
    localparam logic        CFG_IDX_REFRESH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### design/cvrf_ctrl.sv
// Controller state machine of the changed-value report filter.
// Sequences capture, table scan, decision and result hand-off; depends on cvrf_pkg.
`default_nettype none

module cvrf_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire cvrf_pkg::t_status i_status,
    output cvrf_pkg::t_cmd         o_cmd,
    output logic                   o_in_stall
);
    import cvrf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall       = 1'b0;
                o_cmd.load       = i_in_valid;
                o_cmd.scan_start = i_in_valid;
            end
            ST_SCAN: begin
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### design/cvrf_dp.sv
// Datapath of the changed-value report filter: value selection, slot table,
// pipelined scan, store decision and output register. Depends on cvrf_pkg.
`default_nettype none

module cvrf_dp #(
    parameter int unsigned SLOTS = cvrf_pkg::SLOTS_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire cvrf_pkg::t_cmd i_cmd,
    output cvrf_pkg::t_status   o_status,
    input  wire [31:0]          i_refresh_interval_ms,
    input  wire [7:0]           i_message_id,
    input  wire                 i_is_write,
    input  wire [7:0]           i_request_high,
    input  wire [7:0]           i_request_low,
    input  wire [7:0]           i_answer_high,
    input  wire [7:0]           i_answer_low,
    input  wire [31:0]          i_now_ms,
    input  wire                 i_out_stall,
    output logic                o_out_valid,
    output logic                o_publish,
    output logic [7:0]          o_reported_id,
    output logic [15:0]         o_reported_value
);
    import cvrf_pkg::*;

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [7:0]  r_mem_id    [SLOTS];
    logic [15:0] r_mem_value [SLOTS];
    logic [31:0] r_mem_time  [SLOTS];
    logic [SLOTS-1:0] r_slot_valid;

    logic [7:0]  r_in_id;
    logic [15:0] r_in_value;
    logic [31:0] r_in_now;
    logic [15:0] w_sel_value;

    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_active;

    logic             r_s1_go;
    logic             r_s1_last;
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic [7:0]       r_m_id;
    logic [15:0]      r_m_value;
    logic [31:0]      r_m_time;

    logic             r_s2_go;
    logic             r_s2_last;
    logic             r_s2_valid;
    logic [IDX_W-1:0] r_s2_idx;
    logic             r_s2_idm;
    logic             r_s2_eq;
    logic [31:0]      r_s2_age;

    logic             r_scan_done;
    logic             r_hit_found;
    logic             r_hit_eq;
    logic [31:0]      r_hit_age;
    logic             r_ch_found;
    logic [IDX_W-1:0] r_ch_idx;
    logic [31:0]      r_best_age;
    logic [IDX_W-1:0] r_best_idx;

    logic             w_qualifies;
    logic             w_suppress;
    logic [IDX_W-1:0] w_store_idx;

    logic             r_out_valid;
    logic             r_publish;

    always_comb begin
        if (i_message_id == STATUS_ID) begin
            w_sel_value = {i_request_high, i_answer_low};
        end else if (i_is_write) begin
            w_sel_value = {i_request_high, i_request_low};
        end else begin
            w_sel_value = {i_answer_high, i_answer_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_id    <= i_message_id;
            r_in_value <= w_sel_value;
            r_in_now   <= i_now_ms;
        end
    end

    assign w_qualifies = !r_s2_valid || r_s2_idm || (r_s2_age > i_refresh_interval_ms);
    assign w_suppress  = r_hit_found && r_hit_eq && (r_hit_age < i_refresh_interval_ms);
    assign w_store_idx = r_ch_found ? r_ch_idx : r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_active  <= 1'b0;
            r_rd_idx     <= '0;
            r_s1_go      <= 1'b0;
            r_s2_go      <= 1'b0;
            r_scan_done  <= 1'b0;
            r_hit_found  <= 1'b0;
            r_ch_found   <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_rd_active <= 1'b1;
                r_rd_idx    <= '0;
            end else if (r_rd_active) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (r_rd_idx == IDX_W'(SLOTS - 1)) begin
                    r_rd_active <= 1'b0;
                end
            end
            r_s1_go     <= r_rd_active;
            r_s2_go     <= r_s1_go;
            r_scan_done <= r_s2_go && r_s2_last;

            if (i_cmd.scan_start) begin
                r_hit_found <= 1'b0;
                r_ch_found  <= 1'b0;
            end else if (r_s2_go) begin
                if (!r_hit_found && r_s2_valid && r_s2_idm) begin
                    r_hit_found <= 1'b1;
                end
                if (!r_ch_found && w_qualifies) begin
                    r_ch_found <= 1'b1;
                end
            end

            if (i_cmd.decide && !w_suppress) begin
                r_slot_valid[w_store_idx] <= 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_id     <= r_mem_id[r_rd_idx];
        r_m_value  <= r_mem_value[r_rd_idx];
        r_m_time   <= r_mem_time[r_rd_idx];
        r_s1_valid <= r_slot_valid[r_rd_idx];
        r_s1_idx   <= r_rd_idx;
        r_s1_last  <= (r_rd_idx == IDX_W'(SLOTS - 1));

        if (i_cmd.decide && !w_suppress) begin
            r_mem_id[w_store_idx]    <= r_in_id;
            r_mem_value[w_store_idx] <= r_in_value;
            r_mem_time[w_store_idx]  <= r_in_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_valid <= r_s1_valid;
        r_s2_idx   <= r_s1_idx;
        r_s2_last  <= r_s1_last;
        r_s2_idm   <= (r_m_id == r_in_id);
        r_s2_eq    <= (r_m_value == r_in_value);
        r_s2_age   <= r_in_now - r_m_time;

        if (i_cmd.scan_start) begin
            r_best_age <= '0;
            r_best_idx <= '0;
        end else if (r_s2_go) begin
            if (!r_hit_found && r_s2_valid && r_s2_idm) begin
                r_hit_eq  <= r_s2_eq;
                r_hit_age <= r_s2_age;
            end
            if (!r_ch_found) begin
                if (w_qualifies) begin
                    r_ch_idx <= r_s2_idx;
                end else if (r_s2_age > r_best_age) begin
                    r_best_age <= r_s2_age;
                    r_best_idx <= r_s2_idx;
                end
            end
        end

        if (i_cmd.decide) begin
            r_publish <= !w_suppress;
        end
        if (i_cmd.emit) begin
            o_publish        <= r_publish;
            o_reported_id    <= r_in_id;
            o_reported_value <= r_in_value;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.scan_done = r_scan_done;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

### design/changed_value_report_filter_unit.sv
// Changed-value report filter: top level with configuration register,
// controller and datapath. Depends on cvrf_pkg, cvrf_ctrl and cvrf_dp.
//
// Each input transaction carries one observed request/answer pair, its id and
// a millisecond timestamp. A 16-bit value is selected from it and looked up in
// a table of SLOTS entries. One output transaction follows for every input:
// publish is low when the id is known, the value unchanged and the refresh
// interval not yet elapsed. Published values are stored in the table.
// Both channels use valid/stall; a transaction passes when valid is high and
// stall is low. After acceptance the input is looked up by a scan that reads
// one table entry per cycle through a read, age and compare pipeline, then a
// store decision is made and the result is loaded into the output register.
// The input side is stalled until that load, so a new input is only accepted
// once the previous result has reached the output register.
// A finished result waits in the output register while the next input is
// accepted; a second result waits in the controller until the first is taken.
// Reset empties the table and sets the refresh interval to 60000 ms. The
// register at byte address 0 of the APB port holds the refresh interval.
`default_nettype none

module changed_value_report_filter_unit #(
    parameter int unsigned SLOTS = cvrf_pkg::SLOTS_DEFAULT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [cvrf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [31:0]                     pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [7:0]                      i_message_id,
    input  wire                            i_is_write,
    input  wire [7:0]                      i_request_high,
    input  wire [7:0]                      i_request_low,
    input  wire [7:0]                      i_answer_high,
    input  wire [7:0]                      i_answer_low,
    input  wire [31:0]                     i_now_ms,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_publish,
    output logic [7:0]                     o_reported_id,
    output logic [15:0]                    o_reported_value
);
    import cvrf_pkg::*;

    logic [31:0] r_refresh_interval_ms;
    t_cmd        w_cmd;
    t_status     w_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh_interval_ms <= REFRESH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[CFG_ADDR_W-1] == CFG_IDX_REFRESH)) begin
            r_refresh_interval_ms <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr[CFG_ADDR_W-1])
            CFG_IDX_REFRESH: prdata = r_refresh_interval_ms;
            default:         prdata = '0;
        endcase
    end

    cvrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    cvrf_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_refresh_interval_ms (r_refresh_interval_ms),
        .i_message_id          (i_message_id),
        .i_is_write            (i_is_write),
        .i_request_high        (i_request_high),
        .i_request_low         (i_request_low),
        .i_answer_high         (i_answer_high),
        .i_answer_low          (i_answer_low),
        .i_now_ms              (i_now_ms),
        .i_out_stall           (i_out_stall),
        .o_out_valid           (o_out_valid),
        .o_publish             (o_publish),
        .o_reported_id         (o_reported_id),
        .o_reported_value      (o_reported_value)
    );

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.decide, w_cmd.emit}))
        else $error("Controller issued more than one command in a cycle.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input accepted while the previous transaction was in progress.");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("Result loaded over an output transaction that was not taken.");

endmodule

`default_nettype wire

### tb/cvrf_report_checker.sv
// Checker for the changed-value report filter: tracks the refresh register and the slot
// table, predicts one report per accepted input transaction and compares output transactions.
// Depends on cvrf_pkg for the slot count, the status id and the register reset value.
`default_nettype none

module cvrf_report_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [cvrf_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [31:0]  pwdata,
    input  wire         pready,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire [7:0]   i_message_id,
    input  wire         i_is_write,
    input  wire [7:0]   i_request_high,
    input  wire [7:0]   i_request_low,
    input  wire [7:0]   i_answer_high,
    input  wire [7:0]   i_answer_low,
    input  wire [31:0]  i_now_ms,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire         i_publish,
    input  wire [7:0]   i_reported_id,
    input  wire [15:0]  i_reported_value,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = cvrf_pkg::SLOTS_DEFAULT;
    localparam logic [cvrf_pkg::CFG_ADDR_W-1:0] REFRESH_ADDR = {cvrf_pkg::CFG_IDX_REFRESH, 2'b00};

    typedef struct packed {
        logic        publish;
        logic [7:0]  id;
        logic [15:0] value;
    } t_report;

    logic        seen_valid [SLOTS];
    logic [7:0]  seen_id    [SLOTS];
    logic [15:0] seen_value [SLOTS];
    logic [31:0] seen_time  [SLOTS];
    logic [31:0] refresh_ms;
    t_report     expected_reports [$];
    int          failures = 0;

    assign o_fail_count = failures;

    function automatic t_report filter_message(input logic [7:0] id, input logic wr,
                                               input logic [7:0] rh, input logic [7:0] rl,
                                               input logic [7:0] ah, input logic [7:0] al,
                                               input logic [31:0] now);
        t_report     rep;
        logic [15:0] val;
        logic [31:0] age;
        logic [31:0] oldest;
        int          hit;
        int          pick;
        logic        found;
        if (id == cvrf_pkg::STATUS_ID) begin
            val = {rh, al};
        end else if (wr) begin
            val = {rh, rl};
        end else begin
            val = {ah, al};
        end
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && seen_valid[i] && seen_id[i] == id) begin
                hit = i;
            end
        end
        rep.publish = 1'b1;
        rep.id = id;
        rep.value = val;
        if (hit >= 0) begin
            age = now - seen_time[hit];
            if (seen_value[hit] == val && age < refresh_ms) begin
                rep.publish = 1'b0;
            end
        end
        if (rep.publish) begin
            pick = 0;
            oldest = 32'd0;
            found = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                age = now - seen_time[i];
                if (!found) begin
                    if (!seen_valid[i] || seen_id[i] == id || age > refresh_ms) begin
                        pick = i;
                        found = 1'b1;
                    end else if (age > oldest) begin
                        oldest = age;
                        pick = i;
                    end
                end
            end
            seen_valid[pick] = 1'b1;
            seen_id[pick] = id;
            seen_value[pick] = val;
            seen_time[pick] = now;
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_report exp_rep;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                seen_valid[i] = 1'b0;
                seen_id[i] = 8'd0;
                seen_value[i] = 16'd0;
                seen_time[i] = 32'd0;
            end
            refresh_ms = cvrf_pkg::REFRESH_RESET;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REFRESH_ADDR) begin
                refresh_ms = pwdata;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_reports.push_back(filter_message(i_message_id, i_is_write,
                    i_request_high, i_request_low, i_answer_high, i_answer_low, i_now_ms));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected report: publish=%0d id=%0d value=%h",
                                 i_publish, i_reported_id, i_reported_value);
                    end
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (i_publish !== exp_rep.publish || i_reported_id !== exp_rep.id ||
                        i_reported_value !== exp_rep.value) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("mismatch: exp p=%0d id=%0d v=%h, got p=%0d id=%0d v=%h",
                                     exp_rep.publish, exp_rep.id, exp_rep.value,
                                     i_publish, i_reported_id, i_reported_value);
                        end
                    end
                end
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule

`default_nettype wire

### tb/changed_value_report_filter_unit_tb.sv
// Testbench top for the changed-value report filter: drives directed and random message
// transactions, writes the refresh register between phases and gives the verdict.
// Depends on cvrf_pkg, changed_value_report_filter_unit and cvrf_report_checker.
`default_nettype none

module changed_value_report_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = cvrf_pkg::SLOTS_DEFAULT;
    localparam int unsigned SETTLE_CYCLES = SLOTS + 5 + 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [cvrf_pkg::CFG_ADDR_W-1:0] REFRESH_ADDR = {cvrf_pkg::CFG_IDX_REFRESH, 2'b00};
    localparam int POOL = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [cvrf_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    wire  [31:0] prdata;
    wire         pready;
    logic        i_in_valid = 1'b0;
    wire         o_in_stall;
    logic [7:0]  i_message_id = 8'd0;
    logic        i_is_write = 1'b0;
    logic [7:0]  i_request_high = 8'd0;
    logic [7:0]  i_request_low = 8'd0;
    logic [7:0]  i_answer_high = 8'd0;
    logic [7:0]  i_answer_low = 8'd0;
    logic [31:0] i_now_ms = 32'd0;
    wire         o_out_valid;
    logic        i_out_stall = 1'b0;
    wire         o_publish;
    wire  [7:0]  o_reported_id;
    wire  [15:0] o_reported_value;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          stall_mode_left = 0;
    logic [31:0] clock_ms = 32'd0;

    changed_value_report_filter_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_message_id(i_message_id), .i_is_write(i_is_write),
        .i_request_high(i_request_high), .i_request_low(i_request_low),
        .i_answer_high(i_answer_high), .i_answer_low(i_answer_low), .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_publish(o_publish), .o_reported_id(o_reported_id),
        .o_reported_value(o_reported_value)
    );

    cvrf_report_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .pready(pready),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_message_id(i_message_id), .i_is_write(i_is_write),
        .i_request_high(i_request_high), .i_request_low(i_request_low),
        .i_answer_high(i_answer_high), .i_answer_low(i_answer_low), .i_now_ms(i_now_ms),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_publish(o_publish), .i_reported_id(o_reported_id),
        .i_reported_value(o_reported_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("changed_value_report_filter_unit test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(10, 200);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
                i_out_stall <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    task automatic send_message(input logic [7:0] id, input logic wr,
                                input logic [7:0] rh, input logic [7:0] rl,
                                input logic [7:0] ah, input logic [7:0] al,
                                input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_message_id <= id;
        i_is_write <= wr;
        i_request_high <= rh;
        i_request_low <= rl;
        i_answer_high <= ah;
        i_answer_low <= al;
        i_now_ms <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_refresh(input logic [31:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REFRESH_ADDR;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_random(input int count, input logic [31:0] refresh);
        logic [7:0]  pool_id    [POOL];
        logic        pool_wr    [POOL];
        logic [31:0] pool_bytes [POOL];
        logic [31:0] scale;
        logic [31:0] bytes;
        logic [7:0]  id;
        logic        wr;
        int          k;
        int          b;
        scale = refresh / 6;
        if (scale == 0) begin
            scale = 1;
        end
        if (scale > 1000000) begin
            scale = 1000000;
        end
        for (int p = 0; p < POOL; p++) begin
            pool_id[p] = 8'($urandom_range(0, 255));
            pool_wr[p] = 1'($urandom_range(0, 1));
            pool_bytes[p] = $urandom();
        end
        pool_id[0] = cvrf_pkg::STATUS_ID;
        pool_id[1] = 8'hFF;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 40) == 0) begin
                wait_drained();
            end
            if ($urandom_range(0, 19) == 0) begin
                id = 8'($urandom_range(0, 255));
                wr = 1'($urandom_range(0, 1));
                bytes = $urandom();
                clock_ms = $urandom();
            end else begin
                k = $urandom_range(0, POOL - 1);
                if ($urandom_range(0, 9) == 0) begin
                    pool_wr[k] = ~pool_wr[k];
                end
                if ($urandom_range(0, 9) < 4) begin
                    b = $urandom_range(0, 3);
                    pool_bytes[k][8*b +: 8] = 8'($urandom_range(0, 255));
                end
                id = pool_id[k];
                wr = pool_wr[k];
                bytes = pool_bytes[k];
                if ($urandom_range(0, 9) == 0) begin
                    clock_ms = clock_ms + refresh + $urandom_range(0, scale);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, scale);
                end
            end
            send_message(id, wr, bytes[31:24], bytes[23:16], bytes[15:8], bytes[7:0], clock_ms);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_message(cvrf_pkg::STATUS_ID, 1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 32'd0);
        send_message(cvrf_pkg::STATUS_ID, 1'b1, 8'hFF, 8'hAA, 8'h55, 8'hFF, 32'd100);
        send_message(cvrf_pkg::STATUS_ID, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, 32'd200);
        send_message(8'hFF, 1'b1, 8'hA5, 8'h5A, 8'h00, 8'h00, 32'd300);
        send_message(8'hFF, 1'b1, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 32'd60300);
        send_message(8'hFF, 1'b1, 8'hA5, 8'h5A, 8'h12, 8'h34, 32'd120299);
        send_message(8'd7, 1'b0, 8'h11, 8'h22, 8'h12, 8'h34, 32'd120300);
        send_message(8'd7, 1'b0, 8'hFF, 8'hFF, 8'h12, 8'h34, 32'd120301);
        send_message(8'd7, 1'b1, 8'h12, 8'h34, 8'h00, 8'h00, 32'd120302);
        for (int k = 0; k <= SLOTS; k++) begin
            send_message(8'(10 + k), 1'b0, 8'h00, 8'h00, 8'(k), ~8'(k), 32'd2000000);
        end
        send_message(8'd11, 1'b0, 8'h00, 8'h00, 8'd1, ~8'd1, 32'd2000001);
        send_message(8'd10, 1'b0, 8'h00, 8'h00, 8'd0, ~8'd0, 32'd2000001);
        send_message(8'd30, 1'b0, 8'h00, 8'h00, 8'hAB, 8'hCD, 32'hFFFF_FFF0);
        send_message(8'd30, 1'b0, 8'hFF, 8'hFF, 8'hAB, 8'hCD, 32'h0000_0010);

        clock_ms = 32'hFFFF_8000;
        run_random(200, cvrf_pkg::REFRESH_RESET);
        set_refresh(32'd0);
        run_random(150, 32'd0);
        set_refresh(32'hFFFF_FFFF);
        run_random(150, 32'hFFFF_FFFF);
        set_refresh(32'd1);
        run_random(150, 32'd1);
        set_refresh(32'd2500);
        run_random(150, 32'd2500);
        clock_ms = $urandom();
        set_refresh(32'h8000_0000 | $urandom());
        run_random(150, 32'h8000_0000);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("changed_value_report_filter_unit test passed");
        end else begin
            $display("changed_value_report_filter_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
